// ----- src/btn_gest_pkg.sv -----
// ----------------------------------------------------------------------------
// btn_gest_pkg
// shared constants and event codes for the button gesture classifier
// ----------------------------------------------------------------------------
package btn_gest_pkg;

    // tap counter width, any value from 3 to 16
    localparam int unsigned TAP_COUNT_BITS = 8;

    localparam int unsigned TICK_W   = 10;
    localparam int unsigned THR_W    = 14;
    localparam int unsigned TIMER_W  = 14;
    localparam int unsigned EVENT_W  = 3;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 14;

    // timers advance only while below this value
    localparam logic [TIMER_W-1:0] TIMER_LIMIT = TIMER_W'(10000);
    // largest value a timer can reach: limit - 1 + largest tick
    localparam logic [TIMER_W-1:0] TIMER_MAX   = TIMER_W'(11022);

    localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(20);
    localparam logic [THR_W-1:0]  TAP_RESET  = THR_W'(250);
    localparam logic [THR_W-1:0]  IDLE_RESET = THR_W'(500);

    typedef logic [EVENT_W-1:0]        event_t;
    typedef logic [TIMER_W-1:0]        timer_t;
    typedef logic [TAP_COUNT_BITS-1:0] taps_t;

    localparam event_t EV_NONE         = 3'd0;
    localparam event_t EV_PRESS        = 3'd1;
    localparam event_t EV_HOLD         = 3'd2;
    localparam event_t EV_HOLD_RELEASE = 3'd3;
    localparam event_t EV_MULTITAP     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE = 2'd2;

endpackage

// ----- src/button_tap_hold_multitap_classifier.sv -----
// ----------------------------------------------------------------------------
// button_tap_hold_multitap_classifier
// classifies sampled button levels into press, hold, hold release and
// multitap events
// ----------------------------------------------------------------------------
// output: a result is registered and valid in the cycle after its input transfer
// throughput: one level per clock cycle, limited only by the output register
// the next input is taken while a result waits, as long as out_ready frees it
// reset: asynchronous, active low; clears gesture state, arms one multitap
// report and loads tick 20 ms, tap threshold 250 ms, idle threshold 500 ms
module button_tap_hold_multitap_classifier
    import btn_gest_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input level channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  level,
    // result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [EVENT_W-1:0]    event_res,
    output logic [COUNT_W-1:0]    tap_count,
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // configuration registers
    logic [TICK_W-1:0] tick_ms_reg;
    logic [THR_W-1:0]  tap_thr_reg;
    logic [THR_W-1:0]  idle_thr_reg;

    // gesture state
    logic   pressed_reg, pressed_next;
    logic   held_reg, held_next;
    logic   pending_reg, pending_next;
    timer_t press_tmr_reg, press_tmr_next;
    timer_t release_tmr_reg, release_tmr_next;
    taps_t  taps_reg, taps_next;

    // output register
    logic                 out_valid_reg;
    event_t               event_reg, event_next;
    logic [COUNT_W-1:0]   count_reg, count_next;

    logic   in_xfer;
    timer_t press_adv;
    timer_t release_adv;
    logic [TAP_COUNT_BITS+COUNT_W-1:0] taps_ext;

    // the output register frees itself in the same cycle it is drained
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign event_res = event_reg;
    assign tap_count = count_reg;

    // saturating-style timer advance: stops once at or past the limit
    assign press_adv   = (press_tmr_reg < TIMER_LIMIT)
                       ? press_tmr_reg + TIMER_W'(tick_ms_reg) : press_tmr_reg;
    assign release_adv = (release_tmr_reg < TIMER_LIMIT)
                       ? release_tmr_reg + TIMER_W'(tick_ms_reg) : release_tmr_reg;

    // tap count reported through an 8-bit field, zero extended or truncated
    assign taps_ext = {{COUNT_W{1'b0}}, taps_reg};

    always_comb
    begin
        pressed_next     = pressed_reg;
        held_next        = held_reg;
        pending_next     = pending_reg;
        press_tmr_next   = press_tmr_reg;
        release_tmr_next = release_tmr_reg;
        taps_next        = taps_reg;
        event_next       = EV_NONE;
        count_next       = '0;

        if (!pressed_reg && level)
        begin
            // rising edge
            pressed_next   = 1'b1;
            press_tmr_next = '0;
            event_next     = EV_PRESS;
        end
        else if (pressed_reg && !level)
        begin
            // falling edge: arm the report, count a short press as a tap
            pressed_next     = 1'b0;
            pending_next     = 1'b1;
            release_tmr_next = '0;
            if (press_tmr_reg < tap_thr_reg)
            begin
                taps_next = taps_reg + taps_t'(1);
            end
            if (held_reg)
            begin
                held_next  = 1'b0;
                event_next = EV_HOLD_RELEASE;
            end
        end
        else if (pressed_reg && level)
        begin
            // still down: hold starts once past the tap threshold
            press_tmr_next = press_adv;
            if (press_adv > tap_thr_reg && !held_reg)
            begin
                held_next  = 1'b1;
                event_next = EV_HOLD;
            end
        end
        else
        begin
            // still up: report pending taps after the idle time
            release_tmr_next = release_adv;
            if (release_adv > idle_thr_reg && pending_reg)
            begin
                event_next   = EV_MULTITAP;
                count_next   = taps_ext[COUNT_W-1:0];
                taps_next    = '0;
                pending_next = 1'b0;
            end
        end
    end

    // configuration writes, unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_ms_reg  <= TICK_RESET;
            tap_thr_reg  <= TAP_RESET;
            idle_thr_reg <= IDLE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_TICK: tick_ms_reg  <= cfg_wdata[TICK_W-1:0];
                CFG_TAP:  tap_thr_reg  <= cfg_wdata[THR_W-1:0];
                CFG_IDLE: idle_thr_reg <= cfg_wdata[THR_W-1:0];
                default:  ;
            endcase
        end
    end

    // gesture state advances on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg     <= 1'b0;
            held_reg        <= 1'b0;
            pending_reg     <= 1'b1;
            press_tmr_reg   <= '0;
            release_tmr_reg <= '0;
            taps_reg        <= '0;
        end
        else if (in_xfer)
        begin
            pressed_reg     <= pressed_next;
            held_reg        <= held_next;
            pending_reg     <= pending_next;
            press_tmr_reg   <= press_tmr_next;
            release_tmr_reg <= release_tmr_next;
            taps_reg        <= taps_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            event_reg <= event_next;
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    // a hold can only be active while the button is down
    assert property (@(posedge clk) disable iff (!rst_n)
        held_reg |-> pressed_reg)
        else $error("hold active while released");

    // timers never run past the limit plus one tick
    assert property (@(posedge clk) disable iff (!rst_n)
        (press_tmr_reg <= TIMER_MAX) && (release_tmr_reg <= TIMER_MAX))
        else $error("timer beyond its bound");

    // tap count is zero on every result other than a multitap report
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && event_reg != EV_MULTITAP) |-> (count_reg == '0))
        else $error("tap count on a non-multitap result");

    // every input transfer shows up as a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> out_valid_reg)
        else $error("result lost after input transfer");

    // a multitap report clears the pending flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && event_next == EV_MULTITAP) |=> !pending_reg)
        else $error("report still pending after multitap");
`endif

endmodule

// ----- tb/sv/gesture_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gesture_checker
// Watches the level, result and configuration ports of the button gesture
// classifier. It keeps its own model of the gesture state, works out the event
// that each level transfer should give, and compares every result transfer
// with the oldest event still due.
// ----------------------------------------------------------------------------
module gesture_checker
    import btn_gest_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic                  level,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [EVENT_W-1:0]    event_res,
    input  logic [COUNT_W-1:0]    tap_count,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    errors,
    output int                    outstanding
);

    typedef struct packed {
        event_t             ev;
        logic [COUNT_W-1:0] taps;
    } gesture_t;

    // register copies
    logic [TICK_W-1:0] tick_ms;
    logic [THR_W-1:0]  tap_thr_ms;
    logic [THR_W-1:0]  idle_thr_ms;

    // gesture state
    logic   is_down;
    logic   in_hold;
    logic   report_armed;
    timer_t down_ms;
    timer_t up_ms;
    taps_t  tap_tally;

    gesture_t due_gestures[$];

    // timers stop once they reach the limit
    function automatic timer_t advance_ms(timer_t t);
        if (t < TIMER_LIMIT)
        begin
            return t + timer_t'(tick_ms);
        end
        return t;
    endfunction

    function automatic gesture_t classify_level(logic lvl);
        gesture_t g;
        g.ev   = EV_NONE;
        g.taps = '0;
        if (!is_down && lvl)
        begin
            is_down = 1'b1;
            down_ms = '0;
            g.ev    = EV_PRESS;
        end
        else if (is_down && !lvl)
        begin
            is_down      = 1'b0;
            report_armed = 1'b1;
            up_ms        = '0;
            if (down_ms < tap_thr_ms)
            begin
                tap_tally = tap_tally + taps_t'(1);
            end
            if (in_hold)
            begin
                in_hold = 1'b0;
                g.ev    = EV_HOLD_RELEASE;
            end
        end
        else if (is_down)
        begin
            down_ms = advance_ms(down_ms);
            if (down_ms > tap_thr_ms && !in_hold)
            begin
                in_hold = 1'b1;
                g.ev    = EV_HOLD;
            end
        end
        else
        begin
            up_ms = advance_ms(up_ms);
            if (up_ms > idle_thr_ms && report_armed)
            begin
                g.ev         = EV_MULTITAP;
                g.taps       = COUNT_W'(tap_tally);
                tap_tally    = '0;
                report_armed = 1'b0;
            end
        end
        return g;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        gesture_t want;
        if (!rst_n)
        begin
            tick_ms      = TICK_RESET;
            tap_thr_ms   = TAP_RESET;
            idle_thr_ms  = IDLE_RESET;
            is_down      = 1'b0;
            in_hold      = 1'b0;
            report_armed = 1'b1;
            down_ms      = '0;
            up_ms        = '0;
            tap_tally    = '0;
            errors       = 0;
            due_gestures.delete();
        end
        else
        begin
            // results leave before a new level is taken in
            if (out_valid && out_ready)
            begin
                if (due_gestures.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("checker: %0t unexpected result ev %0d taps %0d",
                                 $realtime, event_res, tap_count);
                    end
                end
                else
                begin
                    want = due_gestures.pop_front();
                    if (event_res !== want.ev || tap_count !== want.taps)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("checker: %0t mismatch ev %0d/%0d taps %0d/%0d (exp/got)",
                                     $realtime, want.ev, event_res, want.taps, tap_count);
                        end
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_TICK: tick_ms     = cfg_wdata[TICK_W-1:0];
                    CFG_TAP:  tap_thr_ms  = cfg_wdata[THR_W-1:0];
                    CFG_IDLE: idle_thr_ms = cfg_wdata[THR_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                due_gestures.push_back(classify_level(level));
            end
        end
        outstanding = due_gestures.size();
    end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the button gesture classifier. Levels are sent as
// taps, holds, idle stretches and noise over a series of timing settings,
// with random gaps on the level channel and random stalls on the result
// channel. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import btn_gest_pkg::*;

    // cycles without any transfer before the run is declared hung
    localparam int STALL_LIMIT = 5000;
    // levels per random phase
    localparam int PHASE_ITEMS = 100;
    // taps in the counter wrap burst, more than the counter holds
    localparam int STORM_TAPS  = 270;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  level     = 1'b0;
    logic                  out_ready = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_ready;
    logic                  out_valid;
    logic [EVENT_W-1:0]    event_res;
    logic [COUNT_W-1:0]    tap_count;

    int errors;
    int outstanding;
    int levels_sent  = 0;
    int quiet_cycles = 0;

    // settings currently loaded, used to size the gestures
    int cur_tick = TICK_RESET;
    int cur_tap  = TAP_RESET;
    int cur_idle = IDLE_RESET;

    // stretches with no gaps on either side
    int tx_calm  = 0;
    int rx_calm  = 0;
    int rx_stall = 0;

    always #5 clk = ~clk;

    button_tap_hold_multitap_classifier uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .level     (level),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .event_res (event_res),
        .tap_count (tap_count),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    gesture_checker gesture_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .level       (level),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_res   (event_res),
        .tap_count   (tap_count),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // result side back-pressure: mostly ready, short and long stalls,
    // and now and then a long calm stretch with no stall at all
    always @(negedge clk)
    begin
        int roll;
        if (rx_calm > 0)
        begin
            rx_calm--;
            out_ready <= 1'b1;
        end
        else if (rx_stall > 0)
        begin
            rx_stall--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 2)
            begin
                rx_calm = $urandom_range(50, 300);
            end
            else if (roll < 5)
            begin
                rx_stall = $urandom_range(8, 40);
            end
            else if (roll < 30)
            begin
                rx_stall = $urandom_range(1, 3);
            end
        end
    end

    // hang detection: any transfer on either channel restarts the count
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // idle cycles before the next level transfer, a mix like the result side's
    function automatic int next_gap();
        int roll;
        if (tx_calm > 0)
        begin
            tx_calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2)
        begin
            tx_calm = $urandom_range(40, 200);
            return 0;
        end
        if (roll < 6)
        begin
            return $urandom_range(8, 40);
        end
        if (roll < 30)
        begin
            return $urandom_range(1, 3);
        end
        return 0;
    endfunction

    // one level transfer, valid held with a steady payload until taken
    task automatic send_level(input logic lvl);
        int gap;
        gap = next_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        level    <= lvl;
        do @(posedge clk); while (!in_ready);
        levels_sent++;
    endtask

    task automatic hold_level(input logic lvl, input int ticks);
        repeat (ticks) send_level(lvl);
    endtask

    // stop sending and wait until every due result has been taken
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
    endtask

    // settings change only with the block idle
    task automatic configure(input int tick, input int tap, input int idle);
        drain();
        write_reg(CFG_TICK, tick);
        write_reg(CFG_TAP, tap);
        write_reg(CFG_IDLE, idle);
        @(negedge clk);
        cfg_we   <= 1'b0;
        cur_tick = tick;
        cur_tap  = tap;
        cur_idle = idle;
    endtask

    // one gesture sized from the loaded settings so that taps, holds and
    // reports all happen within a few dozen ticks
    task automatic play_gesture();
        int per_tick;
        int to_hold;
        int to_report;
        int to_limit;
        int roll;
        per_tick  = (cur_tick == 0) ? 1 : cur_tick;
        to_hold   = cur_tap / per_tick + 2;
        to_report = cur_idle / per_tick + 2;
        to_limit  = 10000 / per_tick + 3;
        if (to_hold > 40)
        begin
            to_hold = 40;
        end
        if (to_report > 40)
        begin
            to_report = 40;
        end
        if (to_limit > 60)
        begin
            to_limit = 60;
        end
        roll = $urandom_range(0, 99);
        if (roll < 35)
        begin
            // tap: short press, short release
            hold_level(1'b1, $urandom_range(1, to_hold - 1));
            hold_level(1'b0, $urandom_range(1, 3));
        end
        else if (roll < 55)
        begin
            // press just past the threshold
            hold_level(1'b1, to_hold + $urandom_range(0, 4));
            hold_level(1'b0, $urandom_range(1, 2));
        end
        else if (roll < 62)
        begin
            // long press: the press timer runs into its limit when the tick is large
            hold_level(1'b1, to_limit);
            hold_level(1'b0, 1);
        end
        else if (roll < 85)
        begin
            // idle toward the tap report, reached when the capped stretch is long enough
            hold_level(1'b0, to_report + $urandom_range(0, 3));
        end
        else
        begin
            // noise
            repeat ($urandom_range(1, 8)) send_level($urandom_range(0, 1));
        end
    endtask

    task automatic run_phase(input int items);
        int target;
        target = levels_sent + items;
        while (levels_sent < target)
        begin
            play_gesture();
            // now and then let the results run dry mid-phase
            if ($urandom_range(0, 39) == 0)
            begin
                drain();
            end
        end
    endtask

    initial
    begin
        int tick;
        int tap;
        int idle;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: idling after reset gives one empty tap report
        hold_level(1'b0, 30);
        run_phase(60);

        // directed: tick 1000, tap threshold 2500, report on first idle tick
        configure(1000, 2500, 0);
        hold_level(1'b0, 2);
        send_level(1'b1);           // press
        send_level(1'b0);           // plain release, tap counted
        send_level(1'b1);
        send_level(1'b1);
        send_level(1'b0);           // second tap
        send_level(1'b0);           // report of two taps
        hold_level(1'b1, 4);        // hold start at 3000 ms
        send_level(1'b1);           // no second hold start
        send_level(1'b0);           // hold release, no tap
        send_level(1'b0);           // report of zero taps
        send_level(1'b0);           // nothing armed, quiet
        // zero tap threshold: no press counts as a tap, one tick starts hold
        configure(1, 0, 10000);
        send_level(1'b1);
        send_level(1'b0);
        send_level(1'b1);
        send_level(1'b1);
        send_level(1'b0);

        // fixed settings, extremes among them
        configure(1000, 10000, 10000);
        run_phase(PHASE_ITEMS);
        configure(999, 10000, 0);
        run_phase(PHASE_ITEMS);
        configure(1, 0, 0);
        run_phase(PHASE_ITEMS);
        configure(0, 250, 500);     // zero tick freezes both timers
        run_phase(PHASE_ITEMS);
        configure(20, 250, 500);
        run_phase(PHASE_ITEMS);
        configure(7, 60, 90);
        run_phase(PHASE_ITEMS);
        configure(1000, 0, 10000);
        run_phase(PHASE_ITEMS);

        // random settings with thresholds a few ticks long
        repeat (4)
        begin
            tick = $urandom_range(1, 1000);
            tap  = tick * $urandom_range(0, 12) + $urandom_range(0, tick - 1);
            idle = tick * $urandom_range(0, 12) + $urandom_range(0, tick - 1);
            if (tap > 10000)
            begin
                tap = 10000;
            end
            if (idle > 10000)
            begin
                idle = 10000;
            end
            configure(tick, tap, idle);
            run_phase(PHASE_ITEMS);
        end

        // tap counter wrap: a long burst of taps with no report in between
        configure(1, 10000, 10000);
        repeat (STORM_TAPS)
        begin
            send_level(1'b1);
            send_level(1'b0);
        end
        // zero idle threshold flushes the wrapped count on the next idle tick
        configure(1000, 0, 0);
        hold_level(1'b0, 2);
        run_phase(PHASE_ITEMS);

        drain();
        repeat (10) @(negedge clk);
        if (errors == 0)
        begin
            $display("tb: done, clean");
        end
        else
        begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
